FILE: sv/dmh_pkg.sv
package dmh_pkg;

  localparam int unsigned HeapDepth = 64;
  localparam int unsigned ConnCount = 64;
  localparam int unsigned SlotW = $clog2(HeapDepth);
  localparam int unsigned CountW = $clog2(HeapDepth + 1);
  localparam int unsigned ConnW = 6;
  localparam int unsigned DlW = 32;
  localparam int unsigned TmoW = 16;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RESET = 2'd1,
    REQ_INVAL = 2'd2,
    REQ_POP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INV_RD,
    S_INV_CHK,
    S_ADD,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_MV,
    S_DN_RD,
    S_DN_L,
    S_DN_CMP,
    S_SWAP_A,
    S_SWAP_B,
    S_FIN_RD,
    S_DONE
  } seq_e;

  typedef struct packed {
    logic [DlW-1:0]   deadline;
    logic [ConnW-1:0] conn;
    logic             valid;
  } entry_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ConnW-1:0] connection_id;
    logic [DlW-1:0]   current_time;
    logic [TmoW-1:0]  timeout_seconds;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ConnW-1:0] popped_connection;
    logic             popped_valid;
    logic [DlW-1:0]   popped_deadline;
    logic [DlW-1:0]   earliest_deadline;
    logic [CountW-1:0] entry_count_out;
  } rsp_t;

  // one port of the heap store
  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    entry_t           wdata;
  } hport_t;

endpackage

FILE: sv/dmh_if.sv
interface dmh_req_if import dmh_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dmh_rsp_if import dmh_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/dmh_heap_ram.sv
module dmh_heap_ram import dmh_pkg::*; (
  input  logic   clk_i,
  input  hport_t pa_i,
  input  hport_t pb_i,
  output entry_t ra_o,
  output entry_t rb_o
);
  entry_t mem [HeapDepth];

  // both ports share one process; the sequencer never writes one slot twice a cycle
  always_ff @(posedge clk_i) begin
    if (pa_i.we) mem[pa_i.addr] <= pa_i.wdata;
    if (pb_i.we) mem[pb_i.addr] <= pb_i.wdata;
    ra_o <= mem[pa_i.addr];
    rb_o <= mem[pb_i.addr];
  end
endmodule

FILE: sv/dmh_pos_ram.sv
module dmh_pos_ram import dmh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [ConnW-1:0] waddr_i,
  input  logic [SlotW-1:0] wdata_i,
  input  logic [ConnW-1:0] raddr_i,
  output logic [SlotW-1:0] rdata_o
);
  // valid bit per connection: unwritten entries read as slot zero
  logic [SlotW-1:0] mem [ConnCount];
  logic [ConnCount-1:0] vld_q;
  logic [SlotW-1:0] raw_q;
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    raw_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      hit_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = hit_q ? raw_q : '0;
endmodule

FILE: sv/dmh_seq.sv
module dmh_seq import dmh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dmh_req_if.sink   req,
  dmh_rsp_if.source rsp
);
  seq_e state_q, state_d;
  req_t r_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SlotW-1:0] i_q, i_d, j_q, j_d;
  entry_t e_q, e_d, f_q, f_d;
  logic [1:0] st_q, st_d;
  entry_t pop_q, pop_d;
  logic rsp_v_q, rsp_v_d;
  rsp_t rsp_q, rsp_d;

  hport_t pa, pb;
  entry_t ra, rb;
  logic pw_we;
  logic [ConnW-1:0] pw_addr, pr_addr;
  logic [SlotW-1:0] pw_data, pos_rd;

  dmh_heap_ram u_heap (.clk_i, .pa_i(pa), .pb_i(pb), .ra_o(ra), .rb_o(rb));
  dmh_pos_ram u_pos (
    .clk_i, .rst_ni, .we_i(pw_we), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(pr_addr), .rdata_o(pos_rd)
  );

  // up-heap compare flag, saturating deadline sum and child indices
  logic lt;
  logic [DlW:0] sum;
  logic [DlW-1:0] dl;
  logic [SlotW:0] lidx, ridx;
  assign sum = {1'b0, r_q.current_time} + {{(DlW+1-TmoW){1'b0}}, r_q.timeout_seconds};
  assign dl = sum[DlW] ? '1 : sum[DlW-1:0];
  assign lidx = {i_q, 1'b1};
  assign ridx = {i_q, 1'b0} + (SlotW+1)'(2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (req.valid) begin
        unique case (req_e'(req.data.req_type))
          REQ_POP: state_d = S_POP_RD;
          REQ_ADD: state_d = S_ADD;
          default: state_d = S_INV_RD;
        endcase
      end
      S_INV_RD:  state_d = S_INV_CHK;
      S_INV_CHK: state_d = (r_q.req_type == REQ_INVAL) ? S_FIN_RD : S_ADD;
      S_ADD:     state_d = (cnt_q >= CountW'(HeapDepth)) ? S_FIN_RD : S_UP_RD;
      S_UP_RD:   state_d = (i_q == '0) ? S_FIN_RD : S_UP_CMP;
      S_UP_CMP:  state_d = lt ? S_SWAP_A : S_FIN_RD;
      S_POP_RD:  state_d = (cnt_q == '0) ? S_FIN_RD : S_POP_MV;
      S_POP_MV:  state_d = (cnt_q == CountW'(1)) ? S_FIN_RD : S_DN_RD;
      S_DN_RD:   state_d = S_DN_L;
      S_DN_L:    state_d = S_DN_CMP;
      S_DN_CMP:  state_d = (j_d == i_q) ? S_FIN_RD : S_SWAP_A;
      S_SWAP_A:  state_d = S_SWAP_B;
      S_SWAP_B:  state_d = (r_q.req_type == REQ_POP) ? S_DN_RD : S_UP_RD;
      S_FIN_RD:  state_d = S_DONE;
      S_DONE:    if (!rsp_v_q || rsp.ready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; i_d = i_q; j_d = j_q; e_d = e_q; f_d = f_q;
    st_d = st_q; pop_d = pop_q;
    pa = '0; pb = '0;
    pw_we = 1'b0; pw_addr = '0; pw_data = '0;
    pr_addr = r_q.connection_id;
    lt = 1'b0;
    rsp_v_d = rsp_v_q && !rsp.ready;
    rsp_d = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        st_d = ST_OK; pop_d = '0;
        pr_addr = req.data.connection_id;
      end
      S_INV_RD: pa.addr = pos_rd;
      S_INV_CHK: begin
        if ({1'b0, pos_rd} < cnt_q && ra.valid && ra.conn == r_q.connection_id) begin
          pa.we = 1'b1; pa.addr = pos_rd; pa.wdata = ra; pa.wdata.valid = 1'b0;
        end
      end
      S_ADD: begin
        if (cnt_q >= CountW'(HeapDepth)) st_d = ST_FULL;
        else begin
          i_d = cnt_q[SlotW-1:0];
          e_d = '{deadline: dl, conn: r_q.connection_id, valid: 1'b1};
          pa.we = 1'b1; pa.addr = cnt_q[SlotW-1:0]; pa.wdata = e_d;
          pw_we = 1'b1; pw_addr = r_q.connection_id; pw_data = cnt_q[SlotW-1:0];
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_UP_RD: begin
        j_d = (i_q - 1'b1) >> 1;
        pa.addr = i_q; pb.addr = j_d;
      end
      S_UP_CMP: begin
        lt = ra.deadline < rb.deadline;
        e_d = ra; f_d = rb;
      end
      S_POP_RD: begin
        if (cnt_q == '0) st_d = ST_EMPTY;
        pa.addr = '0; pb.addr = SlotW'(cnt_q - 1'b1);
      end
      S_POP_MV: begin
        pop_d = ra;
        if (!ra.valid) pop_d.conn = '0;
        cnt_d = cnt_q - 1'b1;
        i_d = '0;
        pa.we = 1'b1; pa.addr = '0; pa.wdata = rb;
        if (rb.valid) begin
          pw_we = 1'b1; pw_addr = rb.conn; pw_data = '0;
        end
      end
      S_DN_RD: begin
        j_d = i_q;
        pa.addr = i_q; pb.addr = lidx[SlotW-1:0];
      end
      S_DN_L: begin
        e_d = ra;
        f_d = ra;
        if ({1'b0, lidx} < {1'b0, cnt_q} && rb.deadline < ra.deadline) begin
          j_d = lidx[SlotW-1:0]; f_d = rb;
        end
        pb.addr = ridx[SlotW-1:0];
      end
      S_DN_CMP: begin
        if ({1'b0, ridx} < {1'b0, cnt_q} && rb.deadline < f_q.deadline) begin
          j_d = ridx[SlotW-1:0]; f_d = rb;
        end
      end
      S_SWAP_A: begin
        // write both ends of the swap
        pa.we = 1'b1; pa.addr = i_q; pa.wdata = f_q;
        pb.we = 1'b1; pb.addr = j_q; pb.wdata = e_q;
        if (f_q.valid) begin
          pw_we = 1'b1; pw_addr = f_q.conn; pw_data = i_q;
        end
      end
      S_SWAP_B: begin
        if (e_q.valid) begin
          pw_we = 1'b1; pw_addr = e_q.conn; pw_data = j_q;
        end
        i_d = j_q;
      end
      S_FIN_RD: pa.addr = '0;
      S_DONE: begin
        if (!rsp_v_q || rsp.ready) begin
          rsp_v_d = 1'b1;
          rsp_d.status = st_q;
          rsp_d.popped_connection = pop_q.conn;
          rsp_d.popped_valid = pop_q.valid;
          rsp_d.popped_deadline = pop_q.deadline;
          rsp_d.earliest_deadline = (cnt_q == '0) ? '0 : ra.deadline;
          rsp_d.entry_count_out = cnt_q;
        end
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_v_q;
  assign rsp.data = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      rsp_v_q <= rsp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req.valid) r_q <= req.data;
    i_q <= i_d; j_q <= j_d; e_q <= e_d; f_q <= f_d;
    st_q <= st_d; pop_q <= pop_d; rsp_q <= rsp_d;
  end
endmodule

FILE: sv/deadline_min_heap_timer_queue.sv
// Channel | Dir | Fields
// req     | in  | req_type, connection_id, current_time, timeout_seconds
// rsp     | out | status, popped_*, earliest_deadline, entry_count_out
//
// One request at a time; ready is high only when the sequencer is idle.
// Add: climbs one level per swap (at most 6 levels).
// Reset: invalidate, then add. Full add and empty pop only report status.
// Pop: moves the tail to the root, then descends (at most 5 levels; not for the last entry).
// rst_ni clears the count and the position valid bits at once; no sweep.
// A result beat waits in its register while rsp is stalled; the sequencer holds in S_DONE.
module deadline_min_heap_timer_queue import dmh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dmh_req_if.sink   req,
  dmh_rsp_if.source rsp
);
  // all work happens in the sequencer around the heap store
  dmh_seq u_seq (.clk_i, .rst_ni, .req, .rsp);
endmodule

FILE: sv/dmh_checker.sv
module dmh_sva_checker import dmh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_data_i.entry_count_out <= CountW'(HeapDepth))
    else $error("count out of range");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("ready during work");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_data_i.status == ST_EMPTY) |-> rsp_data_i.entry_count_out == '0)
    else $error("empty status with entries");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result dropped");
endmodule

bind deadline_min_heap_timer_queue dmh_sva_checker u_chk (
  .clk_i, .rst_ni, .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_data_i(rsp.data)
);
